[hdl/cmv_pkg.sv]
// Shared types, constants and the CRC-32 byte fold for the CRC-checked block mirror.
// No dependencies; cmv_verify, the top level and the checker import this package.
package cmv_pkg;

  localparam int unsigned MirrorSlotsDef = 4;
  localparam int unsigned BlockBytesDef  = 512;
  localparam int unsigned LogDepthDef    = 16;

  localparam int unsigned NumCounters = 7;
  localparam int unsigned CntScrubbed = 0;
  localparam int unsigned CntDetected = 1;
  localparam int unsigned CntFixed    = 2;
  localparam int unsigned CntUnrecov  = 3;
  localparam int unsigned CntRuns     = 4;
  localparam int unsigned CntSyncs    = 5;
  localparam int unsigned CntCrcErr   = 6;

  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [8:0]  WindowRst = 9'd16;

  typedef enum logic [2:0] {
    CMD_WRITE, CMD_READ, CMD_SCRUB, CMD_RUN, CMD_FETCH, CMD_STAT, CMD_RECORD, CMD_CLEAR
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK, ST_DISABLED, ST_NO_MIRROR, ST_NO_RECORD
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_VERIFY, S_RUN, S_FETCH_RD, S_LOG_RD, S_DONE
  } state_e;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  typedef struct packed {
    logic        done;
    logic [31:0] crc;
  } verify_res_t;

  function automatic logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hdl/cmv_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module cmv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/cmv_verify.sv]
// Mirror verify engine: sweeps the bytes of one slot out of the mirror RAM and folds them
// into a CRC-32. Depends on cmv_pkg; drives the read port of the mirror RAM.
module cmv_verify
  import cmv_pkg::*;
#(
  parameter int unsigned MirrorSlots = MirrorSlotsDef,
  parameter int unsigned BlockBytes  = BlockBytesDef,
  localparam int unsigned SlotW = (MirrorSlots > 1) ? $clog2(MirrorSlots) : 1,
  localparam int unsigned AddrW = $clog2(MirrorSlots * BlockBytes),
  localparam int unsigned IdxW  = $clog2(BlockBytes)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SlotW-1:0] slot_i,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [7:0]       rd_data_i,
  output verify_res_t      res_o
);

  logic             busy_q;
  logic [IdxW-1:0]  idx_q;
  logic [AddrW-1:0] base_q;
  logic             vld_q;
  logic             last_q;
  logic             done_q;
  logic [31:0]      acc_q;
  logic [31:0]      base_wide;
  logic             idx_last;

  assign base_wide = 32'(slot_i) * 32'(BlockBytes);
  assign idx_last  = (idx_q == IdxW'(BlockBytes - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      vld_q  <= 1'b0;
      last_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= busy_q;
      last_q <= busy_q && idx_last;
      done_q <= vld_q && last_q;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        idx_q <= idx_q + 1'b1;
        if (idx_last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // fold the byte that the RAM returns in the cycle after its address
  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      acc_q <= crc_fold(acc_q, rd_data_i);
    end
    if (start_i) begin
      acc_q  <= CrcInit;
      base_q <= base_wide[AddrW-1:0];
    end
  end

  assign rd_en_o   = busy_q;
  assign rd_addr_o = base_q + AddrW'(idx_q);
  assign res_o     = '{done: done_q, crc: ~acc_q};

endmodule

[hdl/crc_checked_block_mirror_top.sv]
// CRC-checked block mirror: top level with the command sequencer, slot tags and counters.
// Depends on cmv_pkg, cmv_ram (mirror bytes, record ring) and cmv_verify.
//
// Usage: commands arrive as beats on the s_axis channel (command in tuser, last byte of a
// block in tlast); every beat yields exactly one result beat on m_axis. Registers are
// written through cfg_we_i/cfg_index_i/cfg_wdata_i; the user must write them only while
// no command is in flight, as the block itself does not enforce it. A byte write, a
// non-final read byte, stat and clear complete in the execute state. A final read byte,
// fetch or scrub block re-reads each valid slot tagged with that block byte by byte from
// the single read port of the mirror RAM and the verify engine folds it into a CRC-32;
// read and fetch stop at the first slot that passes. Fetch and record add a RAM read.
// A scrub run steps through scrub_window blocks and scrubs each one that has a mirror.
// Throughput: one command at a time; the next beat is accepted as soon as the sequencer
// is idle, even while the previous result still waits in the output register.
// Reset clears tags, valid bits, counters, the record ring pointers and the registers
// (disabled, window 16); mirror bytes are not cleared. A stalled m_axis holds the result
// and the sequencer waits before loading the next one.
module crc_checked_block_mirror_top
  import cmv_pkg::*;
#(
  parameter int unsigned MirrorSlots = MirrorSlotsDef,
  parameter int unsigned BlockBytes  = BlockBytesDef,
  parameter int unsigned LogDepth    = LogDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // block_number[31:0], byte_index[40:32], data_byte[48:41], item_index[52:49], zeros
  input  logic [55:0] s_axis_tdata,
  // command[2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], flag[2], slot[4:3], byte_out[12:5], value[44:13], zeros
  output logic [47:0] m_axis_tdata
);

  localparam int unsigned SlotW = (MirrorSlots > 1) ? $clog2(MirrorSlots) : 1;
  localparam int unsigned ScanW = $clog2(MirrorSlots + 1);
  localparam int unsigned AddrW = $clog2(MirrorSlots * BlockBytes);
  localparam int unsigned LogW  = $clog2(LogDepth);
  localparam int unsigned CntW  = $clog2(LogDepth + 1);

  state_e state_q, state_d;

  logic       enable_q;
  logic [8:0] window_q;

  cmd_e        in_cmd_q;
  logic [31:0] in_blk_q;
  logic [8:0]  in_bidx_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic [3:0]  in_item_q;

  logic [31:0]      tags_q   [MirrorSlots];
  logic [31:0]      tags_d   [MirrorSlots];
  logic [31:0]      checks_q [MirrorSlots];
  logic [31:0]      checks_d [MirrorSlots];
  logic [MirrorSlots-1:0] valid_q, valid_d;
  logic [SlotW-1:0] repl_q, repl_d;
  logic [SlotW-1:0] ss_q, ss_d;
  logic [31:0]      crc_q, crc_d;
  logic [31:0]      cursor_q, cursor_d;
  logic [LogW-1:0]  head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [31:0]      cnt_q [NumCounters];
  logic [NumCounters-1:0] cnt_inc;
  logic [ScanW-1:0] scan_q, scan_d;
  logic [31:0]      blk_sel_q, blk_sel_d;
  logic [31:0]      disk_q, disk_d;
  logic [8:0]       remain_q, remain_d;

  status_e     res_status_q, res_status_d;
  logic        res_flag_q, res_flag_d;
  logic [1:0]  res_slot_q, res_slot_d;
  logic [7:0]  res_byte_q, res_byte_d;
  logic [31:0] res_value_q, res_value_d;

  logic        out_valid_q;
  logic [47:0] out_data_q;

  logic accept, out_free, byte_in_block;
  logic [MirrorSlots-1:0] wr_hit, run_hit_vec;
  logic                   wr_hit_any, run_hit;
  logic [SlotW-1:0]       wr_hit_idx, scan_idx;
  logic                   scan_end, scan_hit, pass;
  logic                   rec_full;
  logic [9:0]             log_idx_wide;
  logic [LogW-1:0]        log_idx;

  logic             ram_we, ram_re, fetch_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr, fetch_addr, eng_addr;
  logic [7:0]       ram_rdata;
  logic             eng_start, eng_rd_en;
  verify_res_t      vres;

  logic        log_we, log_re;
  logic [32:0] log_wdata, log_rdata;
  logic        rec_en, rec_fixed;
  logic [31:0] rec_blk;
  logic [31:0] wr_addr_wide, fetch_addr_wide;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign byte_in_block = (12'(in_bidx_q) < 12'(BlockBytes));

  always_comb begin
    wr_hit_idx = '0;
    for (int s = MirrorSlots - 1; s >= 0; s--) begin
      wr_hit[s]      = valid_q[s] && (tags_q[s] == in_blk_q);
      run_hit_vec[s] = valid_q[s] && (tags_q[s] == cursor_q);
      if (wr_hit[s]) begin
        wr_hit_idx = SlotW'(s);
      end
    end
  end
  assign wr_hit_any = |wr_hit;
  assign run_hit    = |run_hit_vec;

  assign scan_idx = SlotW'(scan_q);
  assign scan_end = (scan_q == ScanW'(MirrorSlots));
  assign scan_hit = !scan_end && valid_q[scan_idx] && (tags_q[scan_idx] == blk_sel_q);
  assign pass     = (vres.crc == checks_q[scan_idx]);
  assign rec_full = (9'(in_item_q) >= 9'(count_q));

  // age 0 is the newest entry, just behind the head
  always_comb begin
    log_idx_wide = 10'(head_q) + 10'(LogDepth) - 10'd1 - 10'(in_item_q);
    if (log_idx_wide >= 10'(LogDepth)) begin
      log_idx_wide = log_idx_wide - 10'(LogDepth);
    end
  end
  assign log_idx = log_idx_wide[LogW-1:0];

  assign fetch_addr_wide = 32'(scan_idx) * 32'(BlockBytes) + 32'(in_bidx_q);
  assign fetch_addr      = fetch_addr_wide[AddrW-1:0];
  assign ram_re          = eng_rd_en || fetch_re;
  assign ram_raddr       = fetch_re ? fetch_addr : eng_addr;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!enable_q) begin
          state_d = S_DONE;
        end else begin
          unique case (in_cmd_q)
            CMD_READ:   state_d = in_last_q ? S_SCAN : S_DONE;
            CMD_SCRUB,
            CMD_FETCH:  state_d = S_SCAN;
            CMD_RUN:    state_d = S_RUN;
            CMD_RECORD: state_d = rec_full ? S_DONE : S_LOG_RD;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_d = (in_cmd_q == CMD_RUN) ? S_RUN : S_DONE;
        end else if (scan_hit) begin
          state_d = S_VERIFY;
        end
      end
      S_VERIFY: begin
        if (vres.done) begin
          if (pass && in_cmd_q == CMD_READ) begin
            state_d = S_DONE;
          end else if (pass && in_cmd_q == CMD_FETCH) begin
            state_d = byte_in_block ? S_FETCH_RD : S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_RUN: begin
        if (remain_q == '0) begin
          state_d = S_DONE;
        end else if (run_hit) begin
          state_d = S_SCAN;
        end
      end
      S_FETCH_RD,
      S_LOG_RD: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer actions
  always_comb begin
    logic [SlotW-1:0] slot_w;
    logic [31:0]      crc_w;
    slot_w       = ss_q;
    crc_w        = crc_q;
    tags_d       = tags_q;
    checks_d     = checks_q;
    valid_d      = valid_q;
    repl_d       = repl_q;
    ss_d         = ss_q;
    crc_d        = crc_q;
    cursor_d     = cursor_q;
    head_d       = head_q;
    count_d      = count_q;
    scan_d       = scan_q;
    blk_sel_d    = blk_sel_q;
    disk_d       = disk_q;
    remain_d     = remain_q;
    res_status_d = res_status_q;
    res_flag_d   = res_flag_q;
    res_slot_d   = res_slot_q;
    res_byte_d   = res_byte_q;
    res_value_d  = res_value_q;
    cnt_inc      = '0;
    ram_we       = 1'b0;
    wr_addr_wide = '0;
    eng_start    = 1'b0;
    fetch_re     = 1'b0;
    log_re       = 1'b0;
    rec_en       = 1'b0;
    rec_fixed    = 1'b0;
    rec_blk      = blk_sel_q;

    unique case (state_q)
      S_EXEC: begin
        res_status_d = ST_OK;
        res_flag_d   = 1'b0;
        res_slot_d   = '0;
        res_byte_d   = '0;
        res_value_d  = '0;
        if (!enable_q) begin
          res_status_d = ST_DISABLED;
        end else begin
          unique case (in_cmd_q)
            CMD_WRITE: begin
              if (in_bidx_q == '0) begin
                if (wr_hit_any) begin
                  slot_w = wr_hit_idx;
                end else begin
                  slot_w = repl_q;
                  repl_d = (repl_q == SlotW'(MirrorSlots - 1)) ? '0 : repl_q + 1'b1;
                end
                tags_d[slot_w]  = in_blk_q;
                valid_d[slot_w] = 1'b0;
                crc_w           = CrcInit;
              end
              ss_d         = slot_w;
              wr_addr_wide = 32'(slot_w) * 32'(BlockBytes) + 32'(in_bidx_q);
              ram_we       = byte_in_block;
              crc_w        = crc_fold(crc_w, in_byte_q);
              if (in_last_q) begin
                tags_d[slot_w]   = in_blk_q;
                checks_d[slot_w] = ~crc_w;
                valid_d[slot_w]  = 1'b1;
                cnt_inc[CntSyncs] = 1'b1;
                crc_w            = CrcInit;
              end
              crc_d      = crc_w;
              res_slot_d = 2'(slot_w);
            end
            CMD_READ: begin
              crc_w = (in_bidx_q == '0) ? CrcInit : crc_q;
              crc_w = crc_fold(crc_w, in_byte_q);
              crc_d = crc_w;
              if (in_last_q) begin
                disk_d    = ~crc_w;
                crc_d     = CrcInit;
                blk_sel_d = in_blk_q;
                scan_d    = '0;
              end
            end
            CMD_SCRUB,
            CMD_FETCH: begin
              blk_sel_d = in_blk_q;
              scan_d    = '0;
            end
            CMD_RUN: begin
              cnt_inc[CntRuns] = 1'b1;
              remain_d         = window_q;
            end
            CMD_STAT: begin
              if (32'(in_item_q) < NumCounters) begin
                res_value_d = cnt_q[in_item_q[2:0]];
              end
            end
            CMD_RECORD: begin
              if (rec_full) begin
                res_status_d = ST_NO_RECORD;
              end else begin
                log_re = 1'b1;
              end
            end
            CMD_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          priority case (in_cmd_q)
            CMD_FETCH: begin
              res_status_d = ST_NO_MIRROR;
              if (in_last_q) begin
                rec_en              = 1'b1;
                cnt_inc[CntUnrecov] = 1'b1;
              end
            end
            CMD_SCRUB,
            CMD_RUN: cnt_inc[CntScrubbed] = 1'b1;
            default: ;
          endcase
        end else if (scan_hit) begin
          eng_start = 1'b1;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_VERIFY: begin
        if (vres.done) begin
          priority case (in_cmd_q)
            CMD_READ: begin
              if (pass) begin
                res_slot_d = 2'(scan_idx);
                if (disk_q != checks_q[scan_idx]) begin
                  res_flag_d           = 1'b1;
                  cnt_inc[CntDetected] = 1'b1;
                  cnt_inc[CntFixed]    = 1'b1;
                  rec_en               = 1'b1;
                  rec_fixed            = 1'b1;
                end
              end else begin
                cnt_inc[CntCrcErr] = 1'b1;
                scan_d             = scan_q + 1'b1;
              end
            end
            CMD_FETCH: begin
              if (pass) begin
                res_flag_d = 1'b1;
                res_slot_d = 2'(scan_idx);
                fetch_re   = byte_in_block;
                if (in_last_q) cnt_inc[CntFixed] = 1'b1;
              end else begin
                scan_d = scan_q + 1'b1;
              end
            end
            default: begin
              // scrub: drop a mirror that fails its check
              if (!pass) begin
                valid_d[scan_idx]    = 1'b0;
                cnt_inc[CntDetected] = 1'b1;
                rec_en               = 1'b1;
              end
              scan_d = scan_q + 1'b1;
            end
          endcase
        end
      end
      S_RUN: begin
        if (remain_q != '0) begin
          cursor_d = cursor_q + 1'b1;
          remain_d = remain_q - 1'b1;
          if (run_hit) begin
            blk_sel_d = cursor_q;
            scan_d    = '0;
          end
        end
      end
      S_FETCH_RD: res_byte_d = ram_rdata;
      S_LOG_RD: begin
        res_value_d = log_rdata[31:0];
        res_flag_d  = log_rdata[32];
      end
      default: ;
    endcase

    if (rec_en) begin
      head_d = (head_q == LogW'(LogDepth - 1)) ? '0 : head_q + 1'b1;
      if (count_q != CntW'(LogDepth)) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  assign ram_waddr = wr_addr_wide[AddrW-1:0];
  assign log_we    = rec_en;
  assign log_wdata = {rec_fixed, rec_blk};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      enable_q    <= 1'b0;
      window_q    <= WindowRst;
      valid_q     <= '0;
      repl_q      <= '0;
      ss_q        <= '0;
      crc_q       <= CrcInit;
      cursor_q    <= '0;
      head_q      <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < MirrorSlots; s++) begin
        tags_q[s]   <= '0;
        checks_q[s] <= '0;
      end
      for (int i = 0; i < NumCounters; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      repl_q   <= repl_d;
      ss_q     <= ss_d;
      crc_q    <= crc_d;
      cursor_q <= cursor_d;
      head_q   <= head_d;
      count_q  <= count_d;
      scan_q   <= scan_d;
      remain_q <= remain_d;
      tags_q   <= tags_d;
      checks_q <= checks_d;
      for (int i = 0; i < NumCounters; i++) begin
        if (cnt_inc[i]) cnt_q[i] <= cnt_q[i] + 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_ENABLE: enable_q <= cfg_wdata_i[0];
          REG_WINDOW: window_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_cmd_q  <= cmd_e'(s_axis_tuser);
      in_blk_q  <= s_axis_tdata[31:0];
      in_bidx_q <= s_axis_tdata[40:32];
      in_byte_q <= s_axis_tdata[48:41];
      in_item_q <= s_axis_tdata[52:49];
      in_last_q <= s_axis_tlast;
    end
    blk_sel_q    <= blk_sel_d;
    disk_q       <= disk_d;
    res_status_q <= res_status_d;
    res_flag_q   <= res_flag_d;
    res_slot_q   <= res_slot_d;
    res_byte_q   <= res_byte_d;
    res_value_q  <= res_value_d;
    if (state_q == S_DONE && out_free) begin
      out_data_q <= {3'd0, res_value_q, res_byte_q, res_slot_q, res_flag_q, res_status_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  cmv_ram #(
    .Width (8),
    .Depth (MirrorSlots * BlockBytes)
  ) u_mirror_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_byte_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cmv_ram #(
    .Width (33),
    .Depth (LogDepth)
  ) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (log_we),
    .waddr_i (head_q),
    .wdata_i (log_wdata),
    .re_i    (log_re),
    .raddr_i (log_idx),
    .rdata_o (log_rdata)
  );

  cmv_verify #(
    .MirrorSlots (MirrorSlots),
    .BlockBytes  (BlockBytes)
  ) u_verify (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (eng_start),
    .slot_i    (scan_idx),
    .rd_en_o   (eng_rd_en),
    .rd_addr_o (eng_addr),
    .rd_data_i (ram_rdata),
    .res_o     (vres)
  );

endmodule

[hdl/cmv_checker.sv]
// Port-level checker for the CRC-checked block mirror, bound to the top level.
// Depends on cmv_pkg; sees only the top level's ports.
module cmv_checker
  import cmv_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic [2:0] pend_q;
  logic       in_beat, out_beat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // commands accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_beat) - 3'(out_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> pend_q <= 3'd2)
    else $error("more than two commands in flight");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 3'd0)
    else $error("result beat without a command");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status_e'(m_axis_tdata[1:0]) != ST_OK) |-> m_axis_tdata[44:2] == '0)
    else $error("error result carries data");

endmodule

bind crc_checked_block_mirror_top cmv_checker u_cmv_checker (.*);
